>>> rtl/iirf_pkg.sv
// ----------------------------------------------------------------------------
// iirf_pkg
// Types, register indexes and the control program of the fourth-order
// direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STEP_W      = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_B0_B1 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_B2_B3 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_B4_A1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_A2_A3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_A4    = 3'd4;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

  // one multiply-accumulate term of the difference equation
  typedef enum logic [3:0] {
    TERM_B0 = 4'd0,
    TERM_B1 = 4'd1,
    TERM_B2 = 4'd2,
    TERM_B3 = 4'd3,
    TERM_B4 = 4'd4,
    TERM_A1 = 4'd5,
    TERM_A2 = 4'd6,
    TERM_A3 = 4'd7,
    TERM_A4 = 4'd8
  } term_t;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_t;

  // control word of one program step
  typedef struct packed {
    logic  mul_en;
    term_t term;
    logic  acc_clr;
    logic  acc_en;
    logic  final_step;
    wait_t wait_on;
  } uword_t;

  // control from the sequencer to the MAC datapath
  typedef struct packed {
    logic mul_en;
    logic mul_fb;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul_en: 1'b0, term: TERM_B0, acc_clr: 1'b0, acc_en: 1'b0,
          final_step: 1'b0, wait_on: WAIT_NONE};
    case (step)
      4'd0: begin
        w.wait_on = WAIT_IN;
      end
      4'd1: begin
        w.mul_en  = 1'b1;
        w.term    = TERM_B0;
        w.acc_clr = 1'b1;
      end
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
        w.mul_en = 1'b1;
        w.term   = term_t'(4'(step - 4'd1));
        w.acc_en = 1'b1;
      end
      4'd10: begin
        w.acc_en = 1'b1;
      end
      4'd11: begin
        w.final_step = 1'b1;
        w.wait_on    = WAIT_OUT;
      end
      default: begin
        w.wait_on = WAIT_IN;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/iir_fourth_order_direct_form_one.sv
// ----------------------------------------------------------------------------
// iir_fourth_order_direct_form_one
// Fourth-order direct form I IIR filter on 16-bit unsigned samples, Q4.28
// coefficients, Q20.12 rounded and saturated output.
// ----------------------------------------------------------------------------
// One sample word in, one filtered word out. A 12-step microprogram runs the
// nine multiply-accumulates on a single shared multiplier: one idle step that
// takes the sample, nine multiply steps, one step to drain the product
// register, and a write-back step that rounds, saturates and updates the
// history. A new sample waits for the idle step. The result sits in an output
// register; the write-back step holds only while that register still carries
// an untaken word. The user must write coefficients through
// cfg_we/cfg_index/cfg_data only while the filter is idle; the block does not
// enforce this. Index 4 keeps the low 32 bits, indexes above 4 are ignored.
module iir_fourth_order_direct_form_one
  import iirf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 28,
  parameter int OUT_FRAC_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [15:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [31:0] filtered
  output logic                   m_tuser    // [0] saturated
);

  logic [63:0] coef_b0_b1;
  logic [63:0] coef_b2_b3;
  logic [63:0] coef_b4_a1;
  logic [63:0] coef_a2_a3;
  logic [31:0] coef_a4;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;

  logic [15:0] x0;
  logic [15:0] xh [4];
  logic [31:0] yh [4];

  logic [31:0]        coef;
  logic signed [32:0] opa;
  logic signed [32:0] opb;
  mac_ctrl_t          mctrl;
  logic [31:0]        y;
  logic               sat;
  logic               out_free;
  logic               write_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0_b1 <= '0;
      coef_b2_b3 <= '0;
      coef_b4_a1 <= '0;
      coef_a2_a3 <= '0;
      coef_a4    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0_B1: coef_b0_b1 <= cfg_data;
        REG_B2_B3: coef_b2_b3 <= cfg_data;
        REG_B4_A1: coef_b4_a1 <= cfg_data;
        REG_A2_A3: coef_a2_a3 <= cfg_data;
        REG_A4:    coef_a4    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign uw         = ucode(step);
  assign out_free   = ~m_tvalid | m_tready;
  assign s_tready   = (uw.wait_on == WAIT_IN);
  assign write_back = uw.final_step & out_free;

  always_comb begin
    step_next = step;
    case (uw.wait_on)
      WAIT_IN:  if (s_tvalid) step_next = STEP_FIRST;
      WAIT_OUT: if (out_free) step_next = STEP_IDLE;
      default:  step_next = 4'(step + 4'd1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // operand selection
  always_comb begin
    coef = '0;
    opb  = '0;
    case (uw.term)
      TERM_B0: begin coef = coef_b0_b1[63:32]; opb = {17'd0, x0};    end
      TERM_B1: begin coef = coef_b0_b1[31:0];  opb = {17'd0, xh[0]}; end
      TERM_B2: begin coef = coef_b2_b3[63:32]; opb = {17'd0, xh[1]}; end
      TERM_B3: begin coef = coef_b2_b3[31:0];  opb = {17'd0, xh[2]}; end
      TERM_B4: begin coef = coef_b4_a1[63:32]; opb = {17'd0, xh[3]}; end
      TERM_A1: begin coef = coef_b4_a1[31:0];  opb = {yh[0][31], yh[0]}; end
      TERM_A2: begin coef = coef_a2_a3[63:32]; opb = {yh[1][31], yh[1]}; end
      TERM_A3: begin coef = coef_a2_a3[31:0];  opb = {yh[2][31], yh[2]}; end
      TERM_A4: begin coef = coef_a4;           opb = {yh[3][31], yh[3]}; end
      default: ;
    endcase
    opa = {coef[31], coef};
  end

  always_comb begin
    mctrl.mul_en  = uw.mul_en;
    mctrl.mul_fb  = (uw.term == TERM_A1) || (uw.term == TERM_A2) ||
                    (uw.term == TERM_A3) || (uw.term == TERM_A4);
    mctrl.acc_clr = uw.acc_clr;
    mctrl.acc_en  = uw.acc_en;
  end

  iirf_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .ctrl (mctrl),
    .opa  (opa),
    .opb  (opb),
    .y    (y),
    .sat  (sat)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x0 <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else if (write_back) begin
      for (int i = 3; i > 0; i--) begin
        xh[i] <= xh[i-1];
        yh[i] <= yh[i-1];
      end
      xh[0] <= x0;
      yh[0] <= y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (write_back) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_back) begin
      m_tdata <= y;
      m_tuser <= sat;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("step counter beyond program end");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (step == STEP_FIRST))
    else $error("accepted word did not start the program");

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    (uw.final_step && m_tvalid && !m_tready) |=> (step == $past(step)))
    else $error("write-back ran over an untaken result");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
    else $error("saturated flag with unclipped value");

endmodule

>>> rtl/iirf_mac.sv
// ----------------------------------------------------------------------------
// iirf_mac
// Shared 33x33 multiplier with a registered product, wide accumulator and
// the round-half-up / saturate stage of the filter output.
// ----------------------------------------------------------------------------
module iirf_mac
  import iirf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 28,
  parameter int OUT_FRAC_BITS  = 12
) (
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic signed [32:0] opa,
  input  logic signed [32:0] opb,
  output logic        [31:0] y,
  output logic               sat
);

  localparam int PROD_W = 66;
  localparam int ACC_W  = 68 + OUT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_fb;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shr;
  logic [ACC_W-32:0]        hi_bits;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod    <= opa * opb;
      prod_fb <= ctrl.mul_fb;
    end
  end

  // feed-forward terms are aligned to the feedback scale; feedback is subtracted
  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    term     = prod_fb ? -prod_ext : (prod_ext <<< OUT_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + term;
    end
  end

  always_comb begin
    rnd     = acc + HALF;
    shr     = rnd >>> COEF_FRAC_BITS;
    hi_bits = shr[ACC_W-1:31];
    fits    = (&hi_bits) | ~(|hi_bits);
    sat     = ~fits;
    if (fits) begin
      y = shr[31:0];
    end else if (rnd[ACC_W-1]) begin
      y = 32'h8000_0000;
    end else begin
      y = 32'h7FFF_FFFF;
    end
  end

endmodule
